// File: rtl/core/svp_pkg.sv
// shared types and constants of the stride value predictor
`default_nettype none

package svp_pkg;

    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_UPDATE  = 1'b1;

    localparam int VALUE_W  = 64;
    localparam int ID_W     = 32;
    localparam int STRIDE_W = 32;
    localparam int CONF_W   = 4;
    localparam int STAT_W   = 32;

    localparam logic [CONF_W-1:0] CONF_MAX = 4'd15;
    localparam logic [CONF_W-1:0] THRESHOLD_RESET = 4'd2;

    // controller to datapath
    typedef struct packed {
        logic clear;      // write an empty entry at the sweep address
        logic take_input; // input side is open, read at the incoming slot
        logic exec;       // finish the held word and write back
    } svp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic out_free;
    } svp_status_t;

endpackage

`default_nettype wire

// File: rtl/core/svp_if.sv
// word channels of the stride value predictor
`default_nettype none

interface svp_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic [31:0]        uop_id;
    logic signed [63:0] value;

    modport source (output valid, output command, output uop_id, output value, input ready);
    modport sink   (input valid, input command, input uop_id, input value, output ready);
endinterface

interface svp_out_if;
    logic               valid;
    logic               ready;
    logic               predicted;
    logic signed [63:0] pred_value;
    logic               confident;
    logic [31:0]        total_count;
    logic [31:0]        correct_count;
    logic [31:0]        confident_count;
    logic [31:0]        correct_confident_count;

    modport source (output valid, output predicted, output pred_value, output confident,
                    output total_count, output correct_count, output confident_count,
                    output correct_confident_count, input ready);
    modport sink   (input valid, input predicted, input pred_value, input confident,
                    input total_count, input correct_count, input confident_count,
                    input correct_confident_count, output ready);
endinterface

`default_nettype wire

// File: rtl/core/svp_ram.sv
// generic single write, single registered read memory
`default_nettype none

module svp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/svp_ctrl.sv
// controller of the stride value predictor
`default_nettype none

module svp_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire svp_pkg::svp_status_t status,
    output svp_pkg::svp_cmd_t         cmd
);
    import svp_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            case (state_reg)
                ST_CLEAR:
                begin
                    if (status.clear_done)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (status.out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd.clear      = (state_reg == ST_CLEAR);
        cmd.take_input = (state_reg == ST_IDLE);
        cmd.exec       = (state_reg == ST_EXEC) && status.out_free;
    end

endmodule

`default_nettype wire

// File: rtl/core/svp_datapath.sv
// table, history and statistics datapath of the stride value predictor
`default_nettype none

module svp_datapath #(
    parameter int TABLE_ENTRIES = 256,
    parameter int HISTORY_DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire svp_pkg::svp_cmd_t cmd,
    output svp_pkg::svp_status_t   status,
    input  wire logic              cfg_we,
    input  wire logic [3:0]        cfg_wdata,
    svp_in_if.sink                 in_ch,
    svp_out_if.source              out_ch
);
    import svp_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int TAG_W  = ID_W - IDX_W;
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int HIX_W  = $clog2(HISTORY_DEPTH);
    localparam int META_W = 1 + TAG_W + FILL_W + STRIDE_W + CONF_W + 1 + VALUE_W;
    localparam int HIST_W = HISTORY_DEPTH * VALUE_W;
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HISTORY_DEPTH);

    // held word
    logic               cmd_reg;
    logic [ID_W-1:0]    id_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [CONF_W-1:0]  thr_reg;
    logic [IDX_W-1:0]   clr_cnt_reg;

    logic [IDX_W-1:0] slot;
    logic [TAG_W-1:0] tag;
    assign slot = id_reg[IDX_W-1:0];
    assign tag  = id_reg[ID_W-1:IDX_W];

    // memories
    logic [IDX_W-1:0]  raddr;
    logic [META_W-1:0] meta_rdata, meta_wdata;
    logic [HIST_W-1:0] hist_rdata, hist_wdata;
    logic              meta_we, hist_we;
    logic [IDX_W-1:0]  meta_waddr;

    assign raddr = cmd.take_input ? in_ch.uop_id[IDX_W-1:0] : slot;

    svp_ram #(.WIDTH(META_W), .DEPTH(TABLE_ENTRIES)) u_meta (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (raddr),
        .rdata (meta_rdata)
    );

    svp_ram #(.WIDTH(HIST_W), .DEPTH(TABLE_ENTRIES)) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (slot),
        .wdata (hist_wdata),
        .raddr (raddr),
        .rdata (hist_rdata)
    );

    // entry fields
    logic                m_valid, m_pflag;
    logic [TAG_W-1:0]    m_tag;
    logic [FILL_W-1:0]   m_fill;
    logic [STRIDE_W-1:0] m_stride;
    logic [CONF_W-1:0]   m_conf;
    logic [VALUE_W-1:0]  m_pval;
    assign {m_valid, m_tag, m_fill, m_stride, m_conf, m_pflag, m_pval} = meta_rdata;

    logic [VALUE_W-1:0] hist [HISTORY_DEPTH];
    logic [VALUE_W-1:0] hist_new [HISTORY_DEPTH];
    always_comb
    begin
        for (int j = 0; j < HISTORY_DEPTH; j++)
        begin
            hist[j] = hist_rdata[j*VALUE_W +: VALUE_W];
            hist_wdata[j*VALUE_W +: VALUE_W] = hist_new[j];
        end
    end

    // statistics
    logic [STAT_W-1:0] total_reg, correct_reg, conf_cnt_reg, corr_conf_reg;

    // next entry and result
    logic                hit, is_const, res_pred, res_conf;
    logic                inc_total, inc_correct, inc_conf, inc_corr_conf;
    logic [FILL_W-1:0]   fill_b, fill_next, fill_m1;
    logic [STRIDE_W-1:0] stride_b, stride_next, s, cur;
    logic [CONF_W-1:0]   conf_b, conf_next;
    logic                pflag_next;
    logic [VALUE_W-1:0]  pval_next, sx, last, pred;

    always_comb
    begin
        hit      = m_valid && (m_tag == tag);
        fill_m1  = m_fill - FILL_W'(1);
        last     = hist[fill_m1[HIX_W-1:0]];
        s        = STRIDE_W'(hist[1] - hist[0]);
        sx       = {{(VALUE_W-STRIDE_W){s[STRIDE_W-1]}}, s};
        is_const = 1'b1;
        for (int i = 2; i < HISTORY_DEPTH; i++)
        begin
            if ((FILL_W'(i) < m_fill) && ((hist[i] - hist[i-1]) != sx))
            begin
                is_const = 1'b0;
            end
        end
        pred = is_const ? last + sx : last;

        fill_b   = hit ? m_fill : '0;
        stride_b = hit ? m_stride : '0;
        conf_b   = hit ? m_conf : '0;

        fill_next     = m_fill;
        stride_next   = m_stride;
        conf_next     = m_conf;
        pflag_next    = m_pflag;
        pval_next     = m_pval;
        hist_new      = hist;
        cur           = '0;
        res_pred      = 1'b0;
        res_conf      = 1'b0;
        inc_total     = 1'b0;
        inc_correct   = 1'b0;
        inc_conf      = 1'b0;
        inc_corr_conf = 1'b0;

        if (cmd_reg == CMD_PREDICT)
        begin
            if (hit)
            begin
                res_conf = (m_conf >= thr_reg);
                if (m_fill >= FILL_W'(2))
                begin
                    res_pred   = 1'b1;
                    inc_total  = 1'b1;
                    inc_conf   = res_conf;
                    pflag_next = 1'b1;
                    pval_next  = pred;
                    if (is_const)
                    begin
                        stride_next = s;
                    end
                end
            end
        end
        else
        begin
            // a new tag restarts the entry before the update
            if (hit && m_pflag && (m_pval == val_reg))
            begin
                inc_correct   = 1'b1;
                inc_corr_conf = (m_conf >= thr_reg);
            end
            pflag_next  = 1'b0;
            pval_next   = hit ? m_pval : '0;
            stride_next = stride_b;
            if (fill_b < FILL_FULL)
            begin
                for (int j = 0; j < HISTORY_DEPTH; j++)
                begin
                    if (FILL_W'(j) == fill_b)
                    begin
                        hist_new[j] = val_reg;
                    end
                end
                fill_next = fill_b + FILL_W'(1);
            end
            else
            begin
                for (int j = 0; j < HISTORY_DEPTH - 1; j++)
                begin
                    hist_new[j] = hist[j+1];
                end
                hist_new[HISTORY_DEPTH-1] = val_reg;
                fill_next = fill_b;
            end
            conf_next = conf_b;
            if (fill_b != '0)
            begin
                // newest difference against the stored stride
                cur = STRIDE_W'(val_reg - last);
                if (cur == stride_b)
                begin
                    if (conf_b < CONF_MAX)
                    begin
                        conf_next = conf_b + CONF_W'(1);
                    end
                end
                else
                begin
                    conf_next = '0;
                end
            end
            res_conf = (conf_next >= thr_reg);
        end
    end

    // a predict miss leaves the entry untouched
    assign meta_we    = cmd.clear || (cmd.exec && ((cmd_reg == CMD_UPDATE) || hit));
    assign meta_waddr = cmd.clear ? clr_cnt_reg : slot;
    assign meta_wdata = cmd.clear ? '0 :
        {1'b1, tag, fill_next, stride_next, conf_next, pflag_next, pval_next};
    assign hist_we    = cmd.exec && (cmd_reg == CMD_UPDATE);

    assign status.clear_done = (clr_cnt_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign status.out_free   = !out_ch.valid || out_ch.ready;
    assign in_ch.ready       = cmd.take_input;

    // input hold
    always_ff @(posedge clk)
    begin
        if (cmd.take_input && in_ch.valid)
        begin
            cmd_reg <= in_ch.command;
            id_reg  <= in_ch.uop_id;
            val_reg <= in_ch.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= THRESHOLD_RESET;
            clr_cnt_reg   <= '0;
            total_reg     <= '0;
            correct_reg   <= '0;
            conf_cnt_reg  <= '0;
            corr_conf_reg <= '0;
            out_ch.valid  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            if (cmd.exec)
            begin
                total_reg     <= total_reg + STAT_W'(inc_total);
                correct_reg   <= correct_reg + STAT_W'(inc_correct);
                conf_cnt_reg  <= conf_cnt_reg + STAT_W'(inc_conf);
                corr_conf_reg <= corr_conf_reg + STAT_W'(inc_corr_conf);
                out_ch.valid  <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_ch.valid <= 1'b0;
            end
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_ch.predicted               <= res_pred;
            out_ch.pred_value              <= res_pred ? pred : '0;
            out_ch.confident               <= res_conf;
            out_ch.total_count             <= total_reg + STAT_W'(inc_total);
            out_ch.correct_count           <= correct_reg + STAT_W'(inc_correct);
            out_ch.confident_count         <= conf_cnt_reg + STAT_W'(inc_conf);
            out_ch.correct_confident_count <= corr_conf_reg + STAT_W'(inc_corr_conf);
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/stride_value_predictor_unit.sv
// top level of the stride value predictor
`default_nettype none

// per-micro-op stride value predictor with a direct-mapped tagged table
// in_ch carries one word per item: command (predict or update), uop_id, value;
//   the low uop_id bits pick the table slot, the rest is compared as tag
// out_ch returns exactly one word per item: prediction, confidence flag and
//   the four wrapping statistics counters as they stand after the item
// cfg_we / cfg_wdata write the 4-bit confidence threshold (reset value 2);
//   write only while no item is in flight
// sequence: an item is accepted in the idle state, where its entry is read from
//   the table memories, then computed and written back in the exec state, which
//   also raises output valid; no new word is taken before that write-back
// the result sits in an output register; if the receiver stalls, one more
//   item is accepted and then held until that register is taken
// reset: a clearing pass walks every entry of the table, one entry per
//   cycle; in_ch.ready stays low until it is done
module stride_value_predictor_unit #(
    parameter int TABLE_ENTRIES = 256,
    parameter int HISTORY_DEPTH = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [3:0] cfg_wdata,
    svp_in_if.sink          in_ch,
    svp_out_if.source       out_ch
);
    import svp_pkg::*;

    svp_cmd_t    cmd;
    svp_status_t status;

    // sequencing: clear sweep, wait for a word, execute
    svp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .status   (status),
        .cmd      (cmd)
    );

    // entry table, history rows, statistics and output register
    svp_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire

// File: tb/tb_stride_value_predictor_unit.sv
// testbench for the stride value predictor: random and directed words checked against a predictor

import svp_pkg::*;

typedef struct packed {
    logic               predicted;
    logic signed [63:0] pred_value;
    logic               confident;
    logic [31:0]        total_count;
    logic [31:0]        correct_count;
    logic [31:0]        confident_count;
    logic [31:0]        correct_confident_count;
} svp_result_t;

class svp_scoreboard;
    bit          slot_valid [256];
    logic [23:0] slot_tag [256];
    logic [63:0] slot_hist [256][4];
    int          slot_fill [256];
    logic [31:0] slot_stride [256];
    logic [3:0]  slot_conf [256];
    logic [63:0] slot_pending [256];
    bit          slot_has_pending [256];
    logic [31:0] stats [4];
    logic [3:0]  threshold;
    svp_result_t pending_results [$];
    int          errors;

    function new();
        threshold = THRESHOLD_RESET;
        errors = 0;
        foreach (slot_valid[i])
        begin
            slot_valid[i] = 0;
            slot_fill[i] = 0;
            slot_stride[i] = 0;
            slot_conf[i] = 0;
            slot_has_pending[i] = 0;
        end
        foreach (stats[i])
            stats[i] = 0;
    endfunction

    // works out the result of one accepted word and queues it
    function void note_word(logic cmd, logic [31:0] id, logic [63:0] val);
        int          slot;
        logic [23:0] tag;
        bit          hit;
        svp_result_t r;
        logic [31:0] s;
        logic [63:0] sx;
        logic [63:0] pred;
        bit          steady;
        int          n;
        slot = id[7:0];
        tag = id[31:8];
        hit = slot_valid[slot] && slot_tag[slot] == tag;
        r = '0;
        if (cmd == CMD_PREDICT)
        begin
            if (hit)
            begin
                n = slot_fill[slot];
                if (n >= 2)
                begin
                    s = slot_hist[slot][1] - slot_hist[slot][0];
                    sx = {{32{s[31]}}, s};
                    steady = 1;
                    for (int i = 2; i < n; i++)
                        if (slot_hist[slot][i] - slot_hist[slot][i-1] != sx)
                            steady = 0;
                    if (steady)
                    begin
                        pred = slot_hist[slot][n-1] + sx;
                        slot_stride[slot] = s;
                    end
                    else
                        pred = slot_hist[slot][n-1];
                    stats[0]++;
                    if (slot_conf[slot] >= threshold)
                        stats[2]++;
                    slot_pending[slot] = pred;
                    slot_has_pending[slot] = 1;
                    r.predicted = 1;
                    r.pred_value = pred;
                end
                r.confident = slot_conf[slot] >= threshold;
            end
        end
        else
        begin
            if (!hit)
            begin
                slot_valid[slot] = 1;
                slot_tag[slot] = tag;
                slot_fill[slot] = 0;
                slot_stride[slot] = 0;
                slot_conf[slot] = 0;
                slot_has_pending[slot] = 0;
            end
            if (slot_has_pending[slot])
            begin
                if (slot_pending[slot] == val)
                begin
                    stats[1]++;
                    if (slot_conf[slot] >= threshold)
                        stats[3]++;
                end
                slot_has_pending[slot] = 0;
            end
            n = slot_fill[slot];
            if (n < 4)
            begin
                slot_hist[slot][n] = val;
                n++;
                slot_fill[slot] = n;
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                    slot_hist[slot][i] = slot_hist[slot][i+1];
                slot_hist[slot][3] = val;
            end
            if (n >= 2)
            begin
                s = slot_hist[slot][n-1] - slot_hist[slot][n-2];
                if (s == slot_stride[slot])
                begin
                    if (slot_conf[slot] < CONF_MAX)
                        slot_conf[slot]++;
                end
                else
                    slot_conf[slot] = 0;
            end
            r.confident = slot_conf[slot] >= threshold;
        end
        r.total_count = stats[0];
        r.correct_count = stats[1];
        r.confident_count = stats[2];
        r.correct_confident_count = stats[3];
        pending_results = {pending_results, r};
    endfunction

    function void check_word(svp_result_t got);
        svp_result_t exp_r;
        if (pending_results.size() == 0)
        begin
            $display("%0t: unexpected word, actual %h", $realtime, got);
            errors++;
            return;
        end
        exp_r = pending_results.pop_front();
        if (got.predicted !== exp_r.predicted)
            $display("%0t: predicted expected %0d actual %0d", $realtime,
                     exp_r.predicted, got.predicted);
        if (got.pred_value !== exp_r.pred_value)
            $display("%0t: pred_value expected %h actual %h", $realtime,
                     exp_r.pred_value, got.pred_value);
        if (got.confident !== exp_r.confident)
            $display("%0t: confident expected %0d actual %0d", $realtime,
                     exp_r.confident, got.confident);
        if (got.total_count !== exp_r.total_count)
            $display("%0t: total_count expected %0d actual %0d", $realtime,
                     exp_r.total_count, got.total_count);
        if (got.correct_count !== exp_r.correct_count)
            $display("%0t: correct_count expected %0d actual %0d", $realtime,
                     exp_r.correct_count, got.correct_count);
        if (got.confident_count !== exp_r.confident_count)
            $display("%0t: confident_count expected %0d actual %0d", $realtime,
                     exp_r.confident_count, got.confident_count);
        if (got.correct_confident_count !== exp_r.correct_confident_count)
            $display("%0t: correct_confident_count expected %0d actual %0d", $realtime,
                     exp_r.correct_confident_count, got.correct_confident_count);
        if (got !== exp_r)
            errors++;
    endfunction
endclass

module tb_stride_value_predictor_unit;
    timeunit 1ns;
    timeprecision 1ps;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [3:0] cfg_wdata;

    svp_in_if  in_ch ();
    svp_out_if out_ch ();

    stride_value_predictor_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    svp_scoreboard sb;
    bit            idle_allowed;  // random gaps on both sides while set
    bit            hold_output;   // long receiver stall in progress
    int            words_sent;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // overall limit: at most 2110 words, each with an optional idle gap and its pass
    // through the unit, plus the reset sweep and the long stall, taken many times over
    initial
    begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

    // sends one word, with an optional idle gap of random length before it
    task automatic send_word(logic cmd, logic [31:0] id, logic [63:0] val);
        if (idle_allowed && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.command <= cmd;
        in_ch.uop_id <= id;
        in_ch.value <= val;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_word(cmd, id, val);
        words_sent++;
    endtask

    task automatic go_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(logic [3:0] thr);
        cfg_we <= 1'b1;
        cfg_wdata <= thr;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.threshold = thr;
    endtask

    // a strided run of updates and predicts on one uop id
    task automatic stride_run(logic [31:0] id, logic [63:0] start, logic [63:0] step, int len);
        logic [63:0] v;
        v = start;
        for (int i = 0; i < len; i++)
        begin
            send_word(CMD_PREDICT, id, 64'($urandom()));
            // occasional break of the pattern
            if ($urandom_range(0, 9) == 0)
                send_word(CMD_UPDATE, id, {$urandom(), $urandom()});
            else
                send_word(CMD_UPDATE, id, v);
            v = v + step;
        end
    endtask

    function automatic logic [31:0] pick_id();
        // few tags per slot so hits dominate, rare full random ids
        if ($urandom_range(0, 15) == 0)
            return $urandom();
        return {24'($urandom_range(0, 2)) << 2 | 24'($urandom_range(0, 1)),
                8'($urandom_range(0, 15))};
    endfunction

    function automatic logic [63:0] pick_step();
        case ($urandom_range(0, 4))
            0: return 64'($signed(32'($urandom_range(0, 8))) - 4);
            1: return {{32{1'b0}}, $urandom()};
            2: return {$urandom(), $urandom()};
            3: return 64'h0000_0001_0000_0000;
            default: return 64'($urandom_range(0, 3));
        endcase
    endfunction

    // result side: random stalls, plus the long hold-off
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                sb.check_word('{out_ch.predicted, out_ch.pred_value, out_ch.confident,
                                out_ch.total_count, out_ch.correct_count,
                                out_ch.confident_count, out_ch.correct_confident_count});
            if (hold_output)
                out_ch.ready <= 1'b0;
            else if (idle_allowed && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        logic [31:0] id;
        sb = new();
        idle_allowed = 1;
        hold_output = 0;
        words_sent = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_PREDICT;
        in_ch.uop_id = '0;
        in_ch.value = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: miss, short history, new tag restart, extremes, wrap, ceiling
        send_word(CMD_PREDICT, 32'h0000_0005, 64'h0);
        send_word(CMD_UPDATE, 32'h0000_0005, 64'h7FFF_FFFF_FFFF_FFFF);
        send_word(CMD_PREDICT, 32'h0000_0005, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(CMD_UPDATE, 32'h0000_0005, 64'h8000_0000_0000_0000);
        send_word(CMD_PREDICT, 32'h0000_0005, 64'h0);
        send_word(CMD_UPDATE, 32'h0000_0005, 64'h8000_0000_0000_0001);
        send_word(CMD_PREDICT, 32'h0000_0005, 64'h0);
        send_word(CMD_PREDICT, 32'hFFFF_FF05, 64'h0);
        send_word(CMD_UPDATE, 32'hFFFF_FFFF, 64'h0);
        send_word(CMD_UPDATE, 32'hFFFF_FFFF, 64'h8000_0000);
        send_word(CMD_PREDICT, 32'hFFFF_FFFF, 64'h0);
        send_word(CMD_UPDATE, 32'hFFFF_FFFF, 64'h1_0000_0000);
        send_word(CMD_PREDICT, 32'hFFFF_FFFF, 64'h0);
        send_word(CMD_UPDATE, 32'hFFFF_FF05, 64'h5);
        go_idle();
        write_threshold(4'd0);
        stride_run(32'h0000_0101, 64'h10, 64'h3, 10);
        go_idle();
        write_threshold(4'd15);
        for (int i = 0; i < 18; i++)
        begin
            send_word(CMD_UPDATE, 32'h0000_0042, 64'(i * 7));
            send_word(CMD_PREDICT, 32'h0000_0042, 64'h0);
        end
        go_idle();

        // random phases across several thresholds
        for (int ph = 0; ph < 5; ph++)
        begin
            write_threshold(ph == 0 ? 4'd2 : 4'($urandom_range(0, 15)));
            if (ph == 1)
            begin
                // long receiver stall while words keep coming
                fork
                    begin
                        hold_output = 1;
                        repeat (60) @(posedge clk);
                        hold_output = 0;
                    end
                join_none
            end
            if (ph == 4)
                idle_allowed = 0;
            for (int k = 0; k < 17; k++)
            begin
                id = pick_id();
                if ($urandom_range(0, 4) == 0)
                    send_word(1'($urandom()), id, {$urandom(), $urandom()});
                else
                    stride_run(id, {$urandom(), $urandom()}, pick_step(),
                               $urandom_range(2, 12));
            end
            go_idle();
        end

        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// File: stride_value_predictor_unit.f
rtl/core/svp_pkg.sv
rtl/core/svp_if.sv
rtl/core/svp_ram.sv
rtl/core/svp_ctrl.sv
rtl/core/svp_datapath.sv
rtl/core/stride_value_predictor_unit.sv
tb/tb_stride_value_predictor_unit.sv
